>>> rtl/core/legendre_series_evaluator_defines.svh
`ifndef LEGENDRE_SERIES_EVALUATOR_DEFINES_SVH
`define LEGENDRE_SERIES_EVALUATOR_DEFINES_SVH

// Assertion helpers for the Legendre series evaluator.
// Both macros expect signals named clk and rst_n in the enclosing scope.

// Same-cycle implication, checked only outside reset.
`define LSEV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("legendre_series_evaluator: assertion failed");

// Next-cycle implication, checked only outside reset.
`define LSEV_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("legendre_series_evaluator: assertion failed");

`endif

>>> rtl/core/lsev_pkg.sv
package lsev_pkg;

    // Highest polynomial degree of the series.
    localparam int MAX_DEGREE = 10;
    localparam int NUM_STEPS  = MAX_DEGREE - 1;

    // Field widths.
    localparam int OP_W    = 1;
    localparam int IDX_W   = 4;
    localparam int COEF_W  = 32;
    localparam int X_W     = 18;
    localparam int OUT_W   = 40;

    // Fixed-point formats.
    localparam int P_FRAC  = 30;
    localparam int X_FRAC  = 16;
    localparam int R_FRAC  = 24;
    localparam int P_W     = 32;

    // Bits that hold the step number l, and also 2l+1.
    localparam int LW       = $clog2(3 * MAX_DEGREE);
    localparam int XP_W     = X_W + P_W;
    localparam int LP_W     = P_W + LW + 1;
    localparam int NUM_W    = XP_W + LW + 2;
    localparam int NUM30_W  = P_W + LW + 2;
    localparam int RECIP_W  = R_FRAC;
    localparam int PROD_W   = NUM30_W + RECIP_W + 1;
    localparam int TERM_W   = COEF_W + P_W;
    localparam int TERM16_W = TERM_W - P_FRAC;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_EVAL  = 1'b1;

    // Constants.
    localparam logic signed [X_W-1:0]    X_ONE      = X_W'(1 << X_FRAC);
    localparam logic signed [X_W-1:0]    X_NEG_ONE  = -X_ONE;
    localparam logic signed [P_W-1:0]    P_ONE      = P_W'(1 << P_FRAC);
    localparam logic signed [NUM_W-1:0]  NUM_HALF   = NUM_W'(1 << (X_FRAC - 1));
    localparam logic signed [PROD_W-1:0] PROD_HALF  = PROD_W'(1 << (R_FRAC - 1));
    localparam logic signed [TERM_W-1:0] TERM_HALF  = TERM_W'(1 << (P_FRAC - 1));

    // One evaluation in flight: point, last two polynomial values,
    // running sum and the coefficient snapshot taken at acceptance.
    typedef struct packed {
        logic signed [X_W-1:0]              x;
        logic signed [P_W-1:0]              p_prev;
        logic signed [P_W-1:0]              p_cur;
        logic signed [OUT_W-1:0]            acc;
        logic [MAX_DEGREE:0][COEF_W-1:0]    coef;
    } lsev_item_t;

endpackage

>>> rtl/core/lsev_step.sv
// One step of the recurrence in four register stages. It adds the term of
// P_l to the running sum and produces P_(l+1).
module lsev_step (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  lsev_pkg::lsev_item_t                 in_item,
    input  logic [lsev_pkg::LW-1:0]              step_l,
    input  logic [lsev_pkg::RECIP_W-1:0]         step_recip,
    input  logic signed [lsev_pkg::COEF_W-1:0]   step_coef,
    output logic                                 out_valid,
    output lsev_pkg::lsev_item_t                 out_item
);

    // Stage 1: products x*P_l, l*P_(l-1) and c_l*P_l.
    logic                                  v1_reg;
    lsev_pkg::lsev_item_t                  item1_reg;
    logic signed [lsev_pkg::XP_W-1:0]      xp1_reg;
    logic signed [lsev_pkg::XP_W-1:0]      xp1_next;
    logic signed [lsev_pkg::LP_W-1:0]      lp1_reg;
    logic signed [lsev_pkg::LP_W-1:0]      lp1_next;
    logic signed [lsev_pkg::TERM_W-1:0]    term1_reg;
    logic signed [lsev_pkg::TERM_W-1:0]    term1_next;

    // Stage 2: numerator rounded to 30 fraction bits, sum updated.
    logic                                  v2_reg;
    lsev_pkg::lsev_item_t                  item2_reg;
    lsev_pkg::lsev_item_t                  item2_next;
    logic signed [lsev_pkg::NUM_W-1:0]     num;
    logic signed [lsev_pkg::NUM_W-1:0]     num_rnd;
    logic signed [lsev_pkg::NUM30_W-1:0]   num30_reg;
    logic signed [lsev_pkg::NUM30_W-1:0]   num30_next;
    logic signed [lsev_pkg::TERM_W-1:0]    term_rnd;
    logic signed [lsev_pkg::TERM16_W-1:0]  term16;

    // Stage 3: multiply by the reciprocal of l+1.
    logic                                  v3_reg;
    lsev_pkg::lsev_item_t                  item3_reg;
    logic signed [lsev_pkg::PROD_W-1:0]    prod3_reg;
    logic signed [lsev_pkg::PROD_W-1:0]    prod3_next;

    // Stage 4: round to the new polynomial value and shift the pair.
    logic                                  v4_reg;
    lsev_pkg::lsev_item_t                  item4_reg;
    lsev_pkg::lsev_item_t                  item4_next;
    logic signed [lsev_pkg::PROD_W-1:0]    prod_rnd;

    always_comb
    begin
        xp1_next   = lsev_pkg::XP_W'(in_item.x) * lsev_pkg::XP_W'(in_item.p_cur);
        lp1_next   = lsev_pkg::LP_W'($signed({1'b0, step_l}))
                     * lsev_pkg::LP_W'(in_item.p_prev);
        term1_next = lsev_pkg::TERM_W'(step_coef) * lsev_pkg::TERM_W'(in_item.p_cur);
    end

    always_comb
    begin
        num        = lsev_pkg::NUM_W'($signed({1'b0, step_l, 1'b1}))
                     * lsev_pkg::NUM_W'(xp1_reg)
                     - (lsev_pkg::NUM_W'(lp1_reg) <<< lsev_pkg::X_FRAC);
        num_rnd    = (num + lsev_pkg::NUM_HALF) >>> lsev_pkg::X_FRAC;
        num30_next = num_rnd[lsev_pkg::NUM30_W-1:0];
        term_rnd   = (term1_reg + lsev_pkg::TERM_HALF) >>> lsev_pkg::P_FRAC;
        term16     = term_rnd[lsev_pkg::TERM16_W-1:0];
        item2_next = item1_reg;
        item2_next.acc = item1_reg.acc + lsev_pkg::OUT_W'(term16);
    end

    always_comb
    begin
        prod3_next = lsev_pkg::PROD_W'(num30_reg)
                     * lsev_pkg::PROD_W'($signed({1'b0, step_recip}));
    end

    always_comb
    begin
        prod_rnd          = (prod3_reg + lsev_pkg::PROD_HALF) >>> lsev_pkg::R_FRAC;
        item4_next        = item3_reg;
        item4_next.p_prev = item3_reg.p_cur;
        item4_next.p_cur  = prod_rnd[lsev_pkg::P_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item1_reg <= in_item;
            xp1_reg   <= xp1_next;
            lp1_reg   <= lp1_next;
            term1_reg <= term1_next;
            item2_reg <= item2_next;
            num30_reg <= num30_next;
            item3_reg <= item2_reg;
            prod3_reg <= prod3_next;
            item4_reg <= item4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = item4_reg;

endmodule

>>> rtl/core/legendre_series_evaluator.sv
// Legendre series evaluator: sum of c_l * P_l(x) for l = 0 .. MAX_DEGREE.
// The request channel (in_valid / in_ready) carries two kinds of request.
// A write (op = OP_WRITE) stores coef_value, signed Q15.16, as coefficient
// coef_index; an index above MAX_DEGREE is dropped. An evaluate request
// (op = OP_EVAL) takes x_point, signed Q1.16, saturated to +-1.0.
// Each evaluate request yields one series_value, signed Q23.16, on the
// result channel (out_valid / out_ready); a write yields nothing.
// Results leave in request order. The recurrence is unrolled: every
// step is four register stages, so one request is taken in every cycle
// while the output is not stalled; writes never stall behind evaluations.
// Each evaluation takes a snapshot of the coefficient table when it is
// accepted, so later writes never disturb evaluations in flight.
// Reset clears all coefficients to zero and empties the pipeline.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
`include "legendre_series_evaluator_defines.svh"

module legendre_series_evaluator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lsev_pkg::OP_W-1:0]           op,
    input  logic [lsev_pkg::IDX_W-1:0]          coef_index,
    input  logic signed [lsev_pkg::COEF_W-1:0]  coef_value,
    input  logic signed [lsev_pkg::X_W-1:0]     x_point,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lsev_pkg::OUT_W-1:0]   series_value
);

    // Global pipeline enable: move whenever the output register is free
    // or is being emptied in this cycle.
    logic advance;

    logic accept;
    logic write_en;

    // Coefficient table, one flop row per degree, cleared by reset.
    logic [lsev_pkg::COEF_W-1:0] coef_table_reg  [lsev_pkg::MAX_DEGREE+1];
    logic [lsev_pkg::COEF_W-1:0] coef_table_next [lsev_pkg::MAX_DEGREE+1];

    // Entry stage: saturated point, P_0, P_1 and the constant term.
    logic                              s0_valid_reg;
    logic                              s0_valid_next;
    lsev_pkg::lsev_item_t              s0_item_reg;
    lsev_pkg::lsev_item_t              s0_item_next;
    logic signed [lsev_pkg::X_W-1:0]   x_sat;

    // Chain of recurrence steps; index 0 is the entry stage.
    logic                  chain_valid [lsev_pkg::NUM_STEPS+1];
    lsev_pkg::lsev_item_t  chain_item  [lsev_pkg::NUM_STEPS+1];

    // Tail: the term of the highest degree, then the output register.
    logic                                 tail1_valid_reg;
    lsev_pkg::lsev_item_t                 tail1_item_reg;
    logic signed [lsev_pkg::TERM_W-1:0]   tail1_term_reg;
    logic signed [lsev_pkg::TERM_W-1:0]   tail1_term_next;
    logic signed [lsev_pkg::TERM_W-1:0]   tail_term_rnd;
    logic signed [lsev_pkg::TERM16_W-1:0] tail_term16;
    logic                                 tail2_valid_reg;
    logic signed [lsev_pkg::OUT_W-1:0]    tail2_acc_reg;
    logic signed [lsev_pkg::OUT_W-1:0]    tail2_acc_next;

    assign advance  = !tail2_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;
    assign write_en = accept && (op == lsev_pkg::OP_WRITE);

    // Coefficient writes land in the table right away; an index that
    // matches no entry simply writes nothing.
    always_comb
    begin
        coef_table_next = coef_table_reg;
        if (write_en)
        begin
            for (int i = 0; i <= lsev_pkg::MAX_DEGREE; i++)
            begin
                if (32'(coef_index) == i)
                begin
                    coef_table_next[i] = coef_value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= lsev_pkg::MAX_DEGREE; i++)
            begin
                coef_table_reg[i] <= '0;
            end
        end
        else
        begin
            coef_table_reg <= coef_table_next;
        end
    end

    // Entry stage. P_0 is one, P_1 is x moved to 30 fraction bits, and the
    // constant term c_0 * P_0 rounds back to c_0 exactly.
    always_comb
    begin
        if (x_point > lsev_pkg::X_ONE)
        begin
            x_sat = lsev_pkg::X_ONE;
        end
        else if (x_point < lsev_pkg::X_NEG_ONE)
        begin
            x_sat = lsev_pkg::X_NEG_ONE;
        end
        else
        begin
            x_sat = x_point;
        end

        s0_valid_next       = accept && (op == lsev_pkg::OP_EVAL);
        s0_item_next.x      = x_sat;
        s0_item_next.p_prev = lsev_pkg::P_ONE;
        s0_item_next.p_cur  = lsev_pkg::P_W'(x_sat) <<< (lsev_pkg::P_FRAC - lsev_pkg::X_FRAC);
        s0_item_next.acc    = lsev_pkg::OUT_W'($signed(coef_table_reg[0]));
        for (int i = 0; i <= lsev_pkg::MAX_DEGREE; i++)
        begin
            s0_item_next.coef[i] = coef_table_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_item_reg <= s0_item_next;
        end
    end

    assign chain_valid[0] = s0_valid_reg;
    assign chain_item[0]  = s0_item_reg;

    // Step l turns (P_(l-1), P_l) into (P_l, P_(l+1)) and adds c_l * P_l.
    // The reciprocal of l+1 carries 24 fraction bits, rounded to nearest.
    for (genvar i = 0; i < lsev_pkg::NUM_STEPS; i++)
    begin : g_step
        localparam int K = i + 2;
        localparam logic [lsev_pkg::RECIP_W-1:0] RECIP =
            lsev_pkg::RECIP_W'(((1 << lsev_pkg::R_FRAC) + K / 2) / K);

        lsev_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .in_valid   (chain_valid[i]),
            .in_item    (chain_item[i]),
            .step_l     (lsev_pkg::LW'(i + 1)),
            .step_recip (RECIP),
            .step_coef  ($signed(chain_item[i].coef[i + 1])),
            .out_valid  (chain_valid[i + 1]),
            .out_item   (chain_item[i + 1])
        );
    end

    // Tail: multiply the top coefficient by P_MAX_DEGREE, then round the
    // term to 16 fraction bits and close the sum in the output register.
    always_comb
    begin
        tail1_term_next = lsev_pkg::TERM_W'($signed(
                              chain_item[lsev_pkg::NUM_STEPS].coef[lsev_pkg::MAX_DEGREE]))
                          * lsev_pkg::TERM_W'(chain_item[lsev_pkg::NUM_STEPS].p_cur);
        tail_term_rnd   = (tail1_term_reg + lsev_pkg::TERM_HALF) >>> lsev_pkg::P_FRAC;
        tail_term16     = tail_term_rnd[lsev_pkg::TERM16_W-1:0];
        tail2_acc_next  = tail1_item_reg.acc + lsev_pkg::OUT_W'(tail_term16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail1_valid_reg <= 1'b0;
            tail2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tail1_valid_reg <= chain_valid[lsev_pkg::NUM_STEPS];
            tail2_valid_reg <= tail1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tail1_item_reg <= chain_item[lsev_pkg::NUM_STEPS];
            tail1_term_reg <= tail1_term_next;
            tail2_acc_reg  <= tail2_acc_next;
        end
    end

    assign out_valid    = tail2_valid_reg;
    assign series_value = tail2_acc_reg;

    // A write request must never start an evaluation.
    `LSEV_ASSERT_NXT(a_write_no_launch, accept && (op == lsev_pkg::OP_WRITE), !s0_valid_reg)

    // An evaluate request must enter the pipeline on the next cycle.
    `LSEV_ASSERT_NXT(a_eval_launch, accept && (op == lsev_pkg::OP_EVAL), s0_valid_reg)

    // While the receiver stalls, the entry stage holds its contents.
    `LSEV_ASSERT_NXT(a_stall_hold, !in_ready, $stable(s0_valid_reg) && $stable(s0_item_reg))

    // A write to degree zero is visible in the table in the next cycle.
    `LSEV_ASSERT_NXT(a_write_lands, write_en && (coef_index == '0), coef_table_reg[0] == $past(coef_value))

endmodule
